>>> rtl/rlcd_pkg.sv
// Shared types, constants and tables for the run/level coefficient decoder.
package rlcd_pkg;

  localparam int unsigned MACROBLOCKS = 144;
  localparam int unsigned MB_W = ($clog2(MACROBLOCKS) > 8) ? $clog2(MACROBLOCKS) : 8;

  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned DC_W       = 10;
  localparam int unsigned LEVEL_W    = 12;
  localparam int unsigned QUANT_W    = 6;
  localparam int unsigned QS_W       = 14;
  localparam int unsigned PROD_W     = 27;
  localparam int unsigned VALUE_W    = 23;
  localparam int unsigned SLOTS      = 6;

  // Register indexes (paddr[4:2])
  localparam logic [2:0] REG_QUANT_SCALE = 3'd0;
  localparam logic [2:0] REG_EOB_ENABLE  = 3'd1;
  localparam logic [2:0] REG_EOB_CODE    = 3'd2;
  localparam logic [2:0] REG_RUN_WIDTH   = 3'd3;
  localparam logic [2:0] REG_LEVEL_WIDTH = 3'd4;
  localparam logic [2:0] REG_SLOT_ORDER  = 3'd5;

  localparam logic [7:0]  QUANT_SCALE_RST = 8'd1;
  localparam logic [15:0] EOB_CODE_RST    = 16'hFE00;
  localparam logic [3:0]  RUN_WIDTH_RST   = 4'd6;
  localparam logic [3:0]  LEVEL_WIDTH_RST = 4'd10;

  localparam logic [5:0] SCAN_TO_NATURAL [64] = '{
    6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
    6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
    6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
    6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
    6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
    6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
    6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
    6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
  };

  // Indexed by {row[2:1], col[2:1]} of the natural index
  localparam logic [5:0] QUAD_QUANT [16] = '{
    6'd10, 6'd20, 6'd14, 6'd13, 6'd18, 6'd37, 6'd22, 6'd28,
    6'd15, 6'd24, 6'd15, 6'd18, 6'd18, 6'd31, 6'd17, 6'd20
  };

  typedef struct packed {
    logic [7:0]  quant_scale;
    logic        eob_enable;
    logic [15:0] eob_code;
    logic [3:0]  run_width;
    logic [3:0]  level_width;
    logic        slot_order;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic scale;
    logic mult;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_MULT,
    ST_ROUND
  } state_e;

  function automatic logic [2:0] block_of_slot(input logic order, input logic [2:0] slot);
    logic [2:0] id;
    id = 3'd0;
    if (!order) begin
      id = (slot < 3'(SLOTS)) ? slot : 3'd0;
    end else begin
      case (slot)
        3'd0:    id = 3'd5;
        3'd1:    id = 3'd4;
        3'd2:    id = 3'd0;
        3'd3:    id = 3'd1;
        3'd4:    id = 3'd2;
        3'd5:    id = 3'd3;
        default: id = 3'd5;
      endcase
    end
    return id;
  endfunction

endpackage

>>> rtl/run_level_coefficient_decoder.sv
// Top level of the run/level coefficient decoder.
//
// Input stream s_axis carries one 16-bit code word per request. The first word
// of each 8x8 block is the DC word; later words are run/level pairs or the
// end-of-block code. Output stream m_axis carries exactly one result per word:
// tdata holds coef_index, coef_value, block_id and macroblock_id, tuser is
// coef_write and tlast is block_end.
// Each word passes through accept, quantizer scale multiply, level multiply,
// then round and load of the output register; the two multiplies run in series
// on one datapath, and a new word is accepted only once the last is loaded.
// The output register lets the next word be accepted and worked on while a
// result waits; if the result still waits when the next word reaches the round
// step, that step holds and then s_axis_tready stays low.
// Reset returns the registers to their defaults and the decoder to expecting a
// DC word at slot 0 of macroblock 0. The APB port writes registers at byte
// address 4*i; pready is always high. Write registers only while idle.
module run_level_coefficient_decoder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [15:0]                     s_axis_tdata_i,   // [15:0] code_word
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [5:0] coef_index, [28:6] coef_value, [31:29] block_id, [39:32] macroblock_id
  output logic [39:0]                     m_axis_tdata_o,
  output logic                            m_axis_tuser_o,   // [0] coef_write
  output logic                            m_axis_tlast_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rlcd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  rlcd_pkg::cfg_t       cfg;
  rlcd_pkg::dp_cmd_t    cmd;
  rlcd_pkg::dp_status_t status;

  logic [5:0]                   coef_index;
  logic [rlcd_pkg::VALUE_W-1:0] coef_value;
  logic [2:0]                   block_id;
  logic [7:0]                   macroblock_id;

  rlcd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rlcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rlcd_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .status_o        (status),
    .code_word_i     (s_axis_tdata_i),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .coef_write_o    (m_axis_tuser_o),
    .coef_index_o    (coef_index),
    .coef_value_o    (coef_value),
    .block_id_o      (block_id),
    .macroblock_id_o (macroblock_id),
    .block_end_o     (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {macroblock_id, block_id, coef_value, coef_index};

endmodule

>>> rtl/rlcd_cfg.sv
// APB-style configuration register file.
module rlcd_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rlcd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output rlcd_pkg::cfg_t                    cfg_o
);

  rlcd_pkg::cfg_t cfg_q;
  logic           wr_en;
  logic [2:0]     reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[4:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.quant_scale <= rlcd_pkg::QUANT_SCALE_RST;
      cfg_q.eob_enable  <= 1'b1;
      cfg_q.eob_code    <= rlcd_pkg::EOB_CODE_RST;
      cfg_q.run_width   <= rlcd_pkg::RUN_WIDTH_RST;
      cfg_q.level_width <= rlcd_pkg::LEVEL_WIDTH_RST;
      cfg_q.slot_order  <= 1'b0;
    end else if (wr_en) begin
      case (reg_sel)
        rlcd_pkg::REG_QUANT_SCALE: cfg_q.quant_scale <= pwdata[7:0];
        rlcd_pkg::REG_EOB_ENABLE:  cfg_q.eob_enable  <= pwdata[0];
        rlcd_pkg::REG_EOB_CODE:    cfg_q.eob_code    <= pwdata[15:0];
        rlcd_pkg::REG_RUN_WIDTH:   cfg_q.run_width   <= pwdata[3:0];
        rlcd_pkg::REG_LEVEL_WIDTH: cfg_q.level_width <= pwdata[3:0];
        rlcd_pkg::REG_SLOT_ORDER:  cfg_q.slot_order  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      rlcd_pkg::REG_QUANT_SCALE: prdata = {24'd0, cfg_q.quant_scale};
      rlcd_pkg::REG_EOB_ENABLE:  prdata = {31'd0, cfg_q.eob_enable};
      rlcd_pkg::REG_EOB_CODE:    prdata = {16'd0, cfg_q.eob_code};
      rlcd_pkg::REG_RUN_WIDTH:   prdata = {28'd0, cfg_q.run_width};
      rlcd_pkg::REG_LEVEL_WIDTH: prdata = {28'd0, cfg_q.level_width};
      rlcd_pkg::REG_SLOT_ORDER:  prdata = {31'd0, cfg_q.slot_order};
      default:                   prdata = 32'd0;
    endcase
  end

endmodule

>>> rtl/rlcd_ctrl.sv
// Sequencing state machine: accept, scale, multiply, round/hand off.
module rlcd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rlcd_pkg::dp_status_t status_i,
  output rlcd_pkg::dp_cmd_t    cmd_o
);

  rlcd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rlcd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      rlcd_pkg::ST_IDLE:  if (in_valid_i) state_d = rlcd_pkg::ST_SCALE;
      rlcd_pkg::ST_SCALE: state_d = rlcd_pkg::ST_MULT;
      rlcd_pkg::ST_MULT:  state_d = rlcd_pkg::ST_ROUND;
      rlcd_pkg::ST_ROUND: if (status_i.out_free) state_d = rlcd_pkg::ST_IDLE;
      default:            state_d = rlcd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = (state_q == rlcd_pkg::ST_IDLE);
    cmd_o.capture = (state_q == rlcd_pkg::ST_IDLE) && in_valid_i;
    cmd_o.scale   = (state_q == rlcd_pkg::ST_SCALE);
    cmd_o.mult    = (state_q == rlcd_pkg::ST_MULT);
    cmd_o.load    = (state_q == rlcd_pkg::ST_ROUND) && status_i.out_free;
  end

`ifndef NO_ASSERTIONS
  a_capture_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == rlcd_pkg::ST_SCALE) && !in_ready_o)
    else $error("capture did not start the scale step");

  a_round_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rlcd_pkg::ST_ROUND) && !status_i.out_free |=> (state_q == rlcd_pkg::ST_ROUND))
    else $error("result left round step while output register was full");
`endif

endmodule

>>> rtl/rlcd_dp.sv
// Datapath: code word decode, block position state, dequantize and output register.
module rlcd_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rlcd_pkg::cfg_t                      cfg_i,
  input  rlcd_pkg::dp_cmd_t                   cmd_i,
  output rlcd_pkg::dp_status_t                status_o,
  input  logic [15:0]                         code_word_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                coef_write_o,
  output logic [5:0]                          coef_index_o,
  output logic [rlcd_pkg::VALUE_W-1:0]        coef_value_o,
  output logic [2:0]                          block_id_o,
  output logic [7:0]                          macroblock_id_o,
  output logic                                block_end_o
);

  // Block position state
  logic                      expect_dc_q, expect_dc_d;
  logic [5:0]                pos_q, pos_d;
  logic [2:0]                slot_q, slot_d;
  logic [rlcd_pkg::MB_W-1:0] mb_q, mb_d;

  // Decode
  logic [3:0]                       rw, lw;
  logic [4:0]                       total, lsh;
  logic [15:0]                      wmask, w, wl;
  logic signed [15:0]               lvl16;
  logic signed [rlcd_pkg::LEVEL_W-1:0] level;
  logic [7:0]                       run;
  logic                             is_eob, skip, past, wr_d, end_d;
  logic [8:0]                       pos_adv;
  logic [5:0]                       natural;

  // Work registers
  logic                                wr_q, end_q, dc_q;
  logic [5:0]                          idx_q;
  logic [rlcd_pkg::DC_W-1:0]           dcval_q;
  logic signed [rlcd_pkg::LEVEL_W-1:0] level_q;
  logic [rlcd_pkg::QUANT_W-1:0]        quad_q;
  logic [2:0]                          bid_q;
  logic [7:0]                          mbid_q;
  logic [rlcd_pkg::QS_W-1:0]           qs_q;
  logic signed [rlcd_pkg::PROD_W-1:0]  prod_q, prod_d, rnd, shifted;
  logic [rlcd_pkg::VALUE_W-1:0]        value_d;

  // Output register
  logic                         out_valid_q;
  logic                         o_write_q, o_end_q;
  logic [5:0]                   o_index_q;
  logic [rlcd_pkg::VALUE_W-1:0] o_value_q;
  logic [2:0]                   o_bid_q;
  logic [7:0]                   o_mbid_q;

  always_comb begin
    rw = (cfg_i.run_width == 4'd0) ? 4'd1 :
         ((cfg_i.run_width > 4'd8) ? 4'd8 : cfg_i.run_width);
    lw = (cfg_i.level_width == 4'd0) ? 4'd1 :
         ((cfg_i.level_width > 4'd12) ? 4'd12 : cfg_i.level_width);
    total = {1'b0, rw} + {1'b0, lw};
    wmask = (total >= 5'd16) ? 16'hFFFF : ~(16'hFFFF << total[3:0]);
    w     = code_word_i & wmask;
    // sign-extend the low lw bits
    lsh   = 5'd16 - {1'b0, lw};
    wl    = w << lsh;
    lvl16 = $signed(wl) >>> lsh;
    level = lvl16[rlcd_pkg::LEVEL_W-1:0];
    run   = 8'(w >> lw) & ~(8'hFF << rw);

    is_eob  = cfg_i.eob_enable && (w == cfg_i.eob_code);
    skip    = !cfg_i.eob_enable && (level == '0);
    pos_adv = 9'(pos_q) + 9'(run) + 9'(skip);
    past    = |pos_adv[8:6];
    natural = rlcd_pkg::SCAN_TO_NATURAL[pos_adv[5:0]];

    wr_d  = expect_dc_q || (!is_eob && !skip && !past);
    end_d = !expect_dc_q &&
            (is_eob || past || (!skip && (pos_adv[5:0] == 6'd63)));

    expect_dc_d = expect_dc_q ? 1'b0 : end_d;
    if (expect_dc_q || end_d) begin
      pos_d = 6'd1;
    end else if (skip) begin
      pos_d = pos_adv[5:0];
    end else begin
      pos_d = pos_adv[5:0] + 6'd1;
    end

    slot_d = slot_q;
    mb_d   = mb_q;
    if (end_d) begin
      if (slot_q >= 3'(rlcd_pkg::SLOTS - 1)) begin
        slot_d = 3'd0;
        mb_d   = (mb_q == rlcd_pkg::MB_W'(rlcd_pkg::MACROBLOCKS - 1)) ? '0 : mb_q + 1'b1;
      end else begin
        slot_d = slot_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_dc_q <= 1'b1;
      pos_q       <= 6'd1;
      slot_q      <= 3'd0;
      mb_q        <= '0;
    end else if (cmd_i.capture) begin
      expect_dc_q <= expect_dc_d;
      pos_q       <= pos_d;
      slot_q      <= slot_d;
      mb_q        <= mb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      wr_q    <= wr_d;
      end_q   <= end_d;
      dc_q    <= expect_dc_q;
      idx_q   <= (wr_d && !expect_dc_q) ? natural : 6'd0;
      dcval_q <= code_word_i[rlcd_pkg::DC_W-1:0];
      level_q <= level;
      quad_q  <= rlcd_pkg::QUAD_QUANT[{natural[5:4], natural[2:1]}];
      bid_q   <= rlcd_pkg::block_of_slot(cfg_i.slot_order, slot_q);
      mbid_q  <= mb_q[7:0];
    end
    if (cmd_i.scale) begin
      qs_q <= rlcd_pkg::QS_W'(quad_q * cfg_i.quant_scale);
    end
    if (cmd_i.mult) begin
      prod_q <= prod_d;
    end
  end

  always_comb begin
    prod_d  = rlcd_pkg::PROD_W'(level_q) *
              $signed({{(rlcd_pkg::PROD_W - rlcd_pkg::QS_W){1'b0}}, qs_q});
    // (x + 4) / 8 truncated toward zero
    rnd     = prod_q + rlcd_pkg::PROD_W'(4);
    shifted = rnd[rlcd_pkg::PROD_W-1] ? ((rnd + rlcd_pkg::PROD_W'(7)) >>> 3) : (rnd >>> 3);
    if (dc_q) begin
      value_d = {{(rlcd_pkg::VALUE_W - rlcd_pkg::DC_W - 3){dcval_q[rlcd_pkg::DC_W-1]}},
                 dcval_q, 3'b000};
    end else if (wr_q) begin
      value_d = shifted[rlcd_pkg::VALUE_W-1:0];
    end else begin
      value_d = '0;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      o_write_q <= wr_q;
      o_end_q   <= end_q;
      o_index_q <= idx_q;
      o_value_q <= value_d;
      o_bid_q   <= bid_q;
      o_mbid_q  <= mbid_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign coef_write_o    = o_write_q;
  assign coef_index_o    = o_index_q;
  assign coef_value_o    = o_value_q;
  assign block_id_o      = o_bid_q;
  assign macroblock_id_o = o_mbid_q;
  assign block_end_o     = o_end_q;

`ifndef NO_ASSERTIONS
  a_dc_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.capture && expect_dc_q |=> !expect_dc_q && (pos_q == 6'd1) && wr_q && (idx_q == 6'd0))
    else $error("DC word did not set up the AC scan");

  a_slot_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.capture && end_d && (slot_q == 3'(rlcd_pkg::SLOTS - 1)) |=> (slot_q == 3'd0))
    else $error("slot did not wrap at macroblock end");
`endif

endmodule

>>> tb/tb_run_level_coefficient_decoder.sv
// Self-checking testbench for the run/level coefficient decoder: directed and random code words.
module tb_run_level_coefficient_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 1000;
  localparam int QUAD_SCALE [16] = '{10, 20, 14, 13, 18, 37, 22, 28,
                                     15, 24, 15, 18, 18, 31, 17, 20};

  typedef struct packed {
    logic        wr;
    logic [5:0]  index;
    logic [22:0] value;
    logic [2:0]  blk;
    logic [7:0]  mb;
    logic        last;
  } coef_t;

  typedef struct {
    bit          is_reg;
    logic [2:0]  reg_idx;
    logic [31:0] data;
    bit          typed;
    coef_t       golden;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        m_axis_tlast_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [rlcd_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  run_level_coefficient_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Decoder state as the checker sees it
  rlcd_pkg::cfg_t cfg_q = '{quant_scale: rlcd_pkg::QUANT_SCALE_RST, eob_enable: 1'b1,
                            eob_code: rlcd_pkg::EOB_CODE_RST,
                            run_width: rlcd_pkg::RUN_WIDTH_RST,
                            level_width: rlcd_pkg::LEVEL_WIDTH_RST, slot_order: 1'b0};
  bit          at_dc = 1'b1;
  int unsigned coef_pos = 1;
  int unsigned slot = 0;
  int unsigned mb_count = 0;
  logic [5:0]  zigzag [64];

  coef_t       pending_coefs [$];
  stim_row_t   stim_rows [$];
  int          mismatches = 0;
  bit          send_burst = 1'b0;
  bit          take_burst = 1'b0;

  initial begin : build_zigzag
    int k;
    int row;
    int col;
    k = 0;
    for (int s = 0; s < 15; s++) begin
      for (int t = 0; t < 8; t++) begin
        row = (s % 2 == 0) ? 7 - t : t;
        col = s - row;
        if (col >= 0 && col < 8) begin
          zigzag[k] = 6'(row * 8 + col);
          k++;
        end
      end
    end
  end

  function automatic int unsigned clamp_width(input int unsigned v, input int unsigned hi);
    return (v < 1) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic longint sign_field(input int unsigned v, input int unsigned bits);
    longint m;
    m = longint'(v) & ((longint'(1) << bits) - 1);
    if (m >= (longint'(1) << (bits - 1))) m -= longint'(1) << bits;
    return m;
  endfunction

  function automatic coef_t coef(input bit wr, input int idx, input int val, input int blk,
                                 input int mb, input bit last);
    coef_t c;
    c.wr    = wr;
    c.index = 6'(idx);
    c.value = 23'(val);
    c.blk   = 3'(blk);
    c.mb    = 8'(mb);
    c.last  = last;
    return c;
  endfunction

  // Advances the decoder state by one word and returns the coefficient it yields
  function automatic coef_t decode_word(input logic [15:0] word);
    coef_t       res;
    int unsigned rw, lw, total, run, pos, nat, qi;
    logic [15:0] w;
    longint      lvl, scaled;
    bit          done;
    res  = '0;
    done = 1'b0;
    rw = clamp_width(cfg_q.run_width, 8);
    lw = clamp_width(cfg_q.level_width, 12);
    total = rw + lw;
    res.blk = cfg_q.slot_order ? ((slot < 2) ? 3'(5 - slot) : 3'(slot - 2)) : 3'(slot);
    res.mb  = 8'(mb_count);
    if (at_dc) begin
      res.wr    = 1'b1;
      res.value = 23'(sign_field(word, 10) * 8);
      at_dc     = 1'b0;
      coef_pos  = 1;
    end else begin
      w   = (total >= 16) ? word : 16'(word & ((1 << total) - 1));
      run = (w >> lw) & ((1 << rw) - 1);
      lvl = sign_field(w, lw);
      pos = coef_pos;
      if (cfg_q.eob_enable && w == cfg_q.eob_code) begin
        done = 1'b1;
      end else if (lvl == 0 && !cfg_q.eob_enable) begin
        pos += run + 1;
        if (pos >= 64) done = 1'b1;
        else coef_pos = pos;
      end else begin
        pos += run;
        if (pos >= 64) begin
          done = 1'b1;
        end else begin
          nat    = zigzag[pos];
          qi     = ((nat >> 4) << 2) | ((nat & 7) >> 1);
          scaled = longint'(QUAD_SCALE[qi]) * longint'(cfg_q.quant_scale);
          res.wr    = 1'b1;
          res.index = 6'(nat);
          res.value = 23'((lvl * scaled + 4) / 8);
          pos++;
          if (pos >= 64) done = 1'b1;
          else coef_pos = pos;
        end
      end
      if (done) begin
        at_dc    = 1'b1;
        coef_pos = 1;
        slot++;
        if (slot >= rlcd_pkg::SLOTS) begin
          slot = 0;
          mb_count = (mb_count + 1 >= rlcd_pkg::MACROBLOCKS) ? 0 : mb_count + 1;
        end
      end
    end
    res.last = done;
    return res;
  endfunction

  // Mostly well-formed run/level words for the current field widths, some noise
  function automatic logic [15:0] pick_word();
    int unsigned rw, lw, total, run, lev, field, r;
    rw = clamp_width(cfg_q.run_width, 8);
    lw = clamp_width(cfg_q.level_width, 12);
    total = rw + lw;
    r = $urandom_range(0, 19);
    if (at_dc || r == 0) return 16'($urandom);
    if (cfg_q.eob_enable && r < 3) begin
      field = cfg_q.eob_code;
    end else begin
      run = (r == 3) ? $urandom : $urandom_range(0, 2);
      case ($urandom_range(0, 5))
        0:       lev = 0;
        1:       lev = (1 << (lw - 1)) - 1;
        2:       lev = 1 << (lw - 1);
        default: lev = $urandom;
      endcase
      field = ((run & ((1 << rw) - 1)) << lw) | (lev & ((1 << lw) - 1));
    end
    if (total >= 16) return 16'(field);
    return 16'(($urandom & ~((1 << total) - 1)) | (field & ((1 << total) - 1)));
  endfunction

  function automatic void add_word(input logic [15:0] word);
    stim_rows.push_back('{1'b0, 3'd0, 32'(word), 1'b0, '0});
  endfunction

  function automatic void add_typed(input logic [15:0] word, input coef_t golden);
    stim_rows.push_back('{1'b0, 3'd0, 32'(word), 1'b1, golden});
  endfunction

  function automatic void add_reg(input logic [2:0] idx, input logic [31:0] data);
    stim_rows.push_back('{1'b1, idx, data, 1'b0, '0});
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      rlcd_pkg::REG_QUANT_SCALE: cfg_q.quant_scale = data[7:0];
      rlcd_pkg::REG_EOB_ENABLE:  cfg_q.eob_enable  = data[0];
      rlcd_pkg::REG_EOB_CODE:    cfg_q.eob_code    = data[15:0];
      rlcd_pkg::REG_RUN_WIDTH:   cfg_q.run_width   = data[3:0];
      rlcd_pkg::REG_LEVEL_WIDTH: cfg_q.level_width = data[3:0];
      rlcd_pkg::REG_SLOT_ORDER:  cfg_q.slot_order  = data[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_word(input logic [15:0] word, input bit typed, input coef_t golden);
    int    gap;
    coef_t predicted;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= word;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = decode_word(word);
    pending_coefs.push_back(typed ? golden : predicted);
  endtask

  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_coefs.size() != 0);
  endtask

  task automatic load_config(input int phase);
    logic [7:0]  scale;
    logic        en, order;
    logic [15:0] code;
    logic [3:0]  rw, lw;
    int unsigned span;
    case (phase)
      0: begin
        scale = 8'd255; en = 1'b1; code = 16'hFFFF; rw = 4'd15; lw = 4'd15; order = 1'b0;
      end
      1: begin
        scale = 8'd0; en = 1'b0; code = 16'h0000; rw = 4'd0; lw = 4'd0; order = 1'b1;
      end
      2: begin
        scale = 8'd1; en = 1'b1; code = 16'h0003; rw = 4'd1; lw = 4'd1; order = 1'b0;
      end
      3: begin
        scale = 8'd255; en = 1'b1; code = 16'($urandom); rw = 4'd8; lw = 4'd12;
        order = 1'b1;
      end
      default: begin
        case ($urandom_range(0, 3))
          0:       scale = 8'd0;
          1:       scale = 8'd255;
          default: scale = 8'($urandom);
        endcase
        en    = 1'($urandom);
        order = 1'($urandom);
        rw    = 4'($urandom);
        lw    = 4'($urandom);
        span  = clamp_width(rw, 8) + clamp_width(lw, 12);
        code  = 16'($urandom);
        // keep the end code reachable most of the time
        if (span < 16 && $urandom_range(0, 3) != 0) code = 16'(code & ((1 << span) - 1));
      end
    endcase
    write_reg(rlcd_pkg::REG_QUANT_SCALE, {24'($urandom), scale});
    write_reg(rlcd_pkg::REG_EOB_ENABLE,  {31'($urandom), en});
    write_reg(rlcd_pkg::REG_EOB_CODE,    {16'($urandom), code});
    write_reg(rlcd_pkg::REG_RUN_WIDTH,   {28'($urandom), rw});
    write_reg(rlcd_pkg::REG_LEVEL_WIDTH, {28'($urandom), lw});
    write_reg(rlcd_pkg::REG_SLOT_ORDER,  {31'($urandom), order});
  endtask

  function automatic void cmp_field(input string name, input logic signed [31:0] want,
                                    input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_coef(input coef_t got);
    coef_t want;
    if (pending_coefs.size() == 0) begin
      $error("coefficient result with no request pending");
      mismatches++;
    end else begin
      want = pending_coefs.pop_front();
      cmp_field("coef_write", want.wr, got.wr);
      cmp_field("coef_index", want.index, got.index);
      cmp_field("coef_value", $signed(want.value), $signed(got.value));
      cmp_field("block_id", want.blk, got.blk);
      cmp_field("macroblock_id", want.mb, got.mb);
      cmp_field("block_end", want.last, got.last);
    end
  endfunction

  initial begin : result_sink
    int stall;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
      stall = take_burst ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      check_coef({m_axis_tuser_o, m_axis_tdata_o[5:0], m_axis_tdata_o[28:6],
                  m_axis_tdata_o[31:29], m_axis_tdata_o[39:32], m_axis_tlast_o});
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (psel && penable)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int extra;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: DC extremes, AC level extremes, zero level, end code
    add_typed(16'h01FF, coef(1, 0, 4088, 0, 0, 0));
    add_typed(16'h0001, coef(1, 1, 1, 0, 0, 0));
    add_typed(16'h0200, coef(1, 8, -639, 0, 0, 0));
    add_typed(16'h0400, coef(1, 9, 0, 0, 0, 0));
    add_typed(16'hFE00, coef(0, 0, 0, 0, 0, 1));
    add_typed(16'h0200, coef(1, 0, -4096, 1, 0, 0));
    // run past the end of the block
    add_typed(16'hFC01, coef(0, 0, 0, 1, 0, 1));
    add_typed(16'hFDFF, coef(1, 0, 4088, 2, 0, 0));
    // coefficient at the last position closes the block
    add_typed(16'hF9FF, coef(1, 63, 1278, 2, 0, 1));
    add_typed(16'h0000, coef(1, 0, 0, 3, 0, 0));
    add_typed(16'h03FF, coef(1, 1, 0, 3, 0, 0));
    add_word(16'h09F6);
    add_word(16'h0000);
    add_word(16'hFE00);
    // skip mode, widest level, largest scale, swapped block order
    add_reg(rlcd_pkg::REG_QUANT_SCALE, 32'd255);
    add_reg(rlcd_pkg::REG_EOB_ENABLE, 32'd0);
    add_reg(rlcd_pkg::REG_EOB_CODE, 32'd0);
    add_reg(rlcd_pkg::REG_RUN_WIDTH, 32'd4);
    add_reg(rlcd_pkg::REG_LEVEL_WIDTH, 32'd12);
    add_reg(rlcd_pkg::REG_SLOT_ORDER, 32'd1);
    add_word(16'h8155);
    add_typed(16'hB800, coef(1, 18, -2415359, 2, 0, 0));
    add_word(16'h07FF);
    add_word(16'h5000);
    add_word(16'h0000);
    add_word(16'hF000);
    add_word(16'hF000);
    add_word(16'hF000);
    add_reg(rlcd_pkg::REG_QUANT_SCALE, 32'd0);
    add_word(16'h03FF);
    add_word(16'h07FF);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_reg) begin
        wait_idle();
        write_reg(stim_rows[i].reg_idx, stim_rows[i].data);
      end else begin
        send_word(16'(stim_rows[i].data), stim_rows[i].typed, stim_rows[i].golden);
      end
    end

    for (int p = 0; p < 10; p++) begin
      wait_idle();
      load_config(p);
      repeat (20) send_word(pick_word(), 1'b0, '0);
    end

    // Two-word blocks until the macroblock counter wraps, then one block past it
    wait_idle();
    write_reg(rlcd_pkg::REG_QUANT_SCALE, 32'($urandom_range(0, 255)));
    write_reg(rlcd_pkg::REG_EOB_ENABLE, 32'd1);
    write_reg(rlcd_pkg::REG_EOB_CODE, 32'($urandom_range(0, 16'hFFFF)));
    write_reg(rlcd_pkg::REG_RUN_WIDTH, 32'(rlcd_pkg::RUN_WIDTH_RST));
    write_reg(rlcd_pkg::REG_LEVEL_WIDTH, 32'(rlcd_pkg::LEVEL_WIDTH_RST));
    write_reg(rlcd_pkg::REG_SLOT_ORDER, 32'($urandom_range(0, 1)));
    while (!at_dc) send_word(cfg_q.eob_code, 1'b0, '0);
    extra = 0;
    while (extra < 2) begin
      send_word(16'($urandom), 1'b0, '0);
      if ($urandom_range(0, 1)) send_word(cfg_q.eob_code, 1'b0, '0);
      else send_word({6'd63, 10'($urandom_range(1, 1023))}, 1'b0, '0);
      if (extra > 0 || (mb_count == 0 && slot == 0)) extra++;
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
